// ===== design/pdcs_pkg.sv =====
// Shared constants and types for the phase DAC code stepper.
package pdcs_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int DAC_W       = 6;
   localparam int GM_W        = 3;
   localparam int COUNT_W     = 8;

   // Special DAC values around a segment boundary
   localparam logic [DAC_W-1:0] DAC_SEG_LOW = 6'd48;
   localparam logic [DAC_W-1:0] DAC_TURN    = 6'd49;
   localparam logic [DAC_W-1:0] DAC_ALT     = 6'd50;
   localparam logic [DAC_W-1:0] DAC_TOP     = 6'd51;
   localparam logic [DAC_W-1:0] DAC_ZERO    = 6'd0;

   localparam logic [GM_W-1:0] GM_TOP  = 3'd7;
   localparam logic [GM_W-1:0] GM_PEN  = 3'd6;
   localparam logic [GM_W-1:0] GM_ONE  = 3'd1;

   localparam logic [REQ_TUSER_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [REQ_TUSER_W-1:0] CMD_UP   = 2'd1;
   localparam logic [REQ_TUSER_W-1:0] CMD_DOWN = 2'd2;

   typedef struct packed {
      logic [DAC_W-1:0] dac;
      logic [GM_W-1:0]  gm;
      logic             dummy;
   } code_type;

   function automatic logic [GM_W-1:0] to_gray(input logic [GM_W-1:0] bin);
      to_gray = bin ^ (bin >> 1);
   endfunction

endpackage

// ===== design/phase_dac_code_stepper_core.sv =====
// Phase DAC code stepper: sequenced one-position-per-cycle walk through the code space.
//
// Each transaction on req_ is a command: load the code, or step it up or down
// step_count positions (0 counts as 1); other commands leave the code as it is.
// One shared move unit advances the code by one position per clock in the step
// state. A load goes from idle to the finish state; a step goes through the step
// state first. A step ends early when the walk stops at an end of the code space
// (end flag set). In the finish state the code is loaded into the result register
// and the sequencer goes back to idle. A finished command waits in the sequencer
// while an earlier result is still held on rsp_. One command is in progress at a
// time; req_tready is high only when the sequencer is idle, and the result
// register lets a new command be taken while the previous result still waits on
// rsp_.
module phase_dac_code_stepper_core import pdcs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] step_count, [13:8] load_dac, [16:14] load_gm, [17] load_dummy, [23:18] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [5:0] dac_code, [8:6] gm_binary, [11:9] gm_gray, [12] dummy_clock,
   // [13] end_stop, [15:14] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_FINISH} state_type;

   state_type          state_ff;
   code_type           code_ff;
   logic               up_ff;
   logic [COUNT_W-1:0] remain_ff;
   logic               hit_ff;
   logic               rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [COUNT_W-1:0] req_count;
   logic [DAC_W-1:0]   req_dac;
   logic [GM_W-1:0]    req_gm;
   logic               req_dummy;
   logic               accept;
   logic               slot_free;

   code_type           move_code;
   logic               move_hit;

   assign req_count = req_tdata[7:0];
   assign req_dac   = req_tdata[13:8];
   assign req_gm    = req_tdata[16:14];
   assign req_dummy = req_tdata[17];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Shared move unit: one position up or down
   always_comb begin
      move_code = code_ff;
      move_hit  = 1'b0;
      if (up_ff) begin
         if (code_ff.dac == DAC_TURN) begin
            if (code_ff.gm == GM_PEN) begin
               move_code.dac   = DAC_TOP;
               move_code.dummy = 1'b0;
            end else if (code_ff.gm == GM_TOP) begin
               move_code.dac = DAC_SEG_LOW;
            end else begin
               move_code.dac   = DAC_ALT;
               move_code.dummy = 1'b0;
            end
         end else if (code_ff.dac == DAC_ALT || code_ff.dac == DAC_TOP) begin
            if (code_ff.gm == GM_PEN) begin
               move_code.dac   = DAC_TURN;
               move_code.gm    = GM_TOP;
               move_code.dummy = 1'b1;
            end else if (code_ff.gm == GM_TOP) begin
               move_hit = 1'b1;
            end else begin
               move_code.dac   = DAC_ZERO;
               move_code.gm    = code_ff.gm + GM_ONE;
               move_code.dummy = 1'b1;
            end
         end else if (code_ff.gm == GM_TOP) begin
            if (code_ff.dac == DAC_ZERO) begin
               move_hit = 1'b1;
            end else begin
               move_code.dac = code_ff.dac - 6'd1;
            end
         end else begin
            move_code.dac = code_ff.dac + 6'd1;
         end
      end else begin
         if (code_ff.gm == GM_TOP) begin
            if (code_ff.dac == DAC_TURN) begin
               move_code.dac   = DAC_TOP;
               move_code.gm    = GM_PEN;
               move_code.dummy = 1'b0;
            end else if (code_ff.dac == DAC_ALT || code_ff.dac == DAC_TOP) begin
               move_hit = 1'b1;
            end else begin
               move_code.dac = code_ff.dac + 6'd1;
            end
         end else if (code_ff.dac == DAC_ALT || code_ff.dac == DAC_TOP) begin
            move_code.dac   = DAC_TURN;
            move_code.dummy = 1'b1;
         end else if (code_ff.dac == DAC_ZERO) begin
            if (code_ff.gm > GM_ONE) begin
               move_code.gm    = code_ff.gm - GM_ONE;
               move_code.dac   = DAC_TOP;
               move_code.dummy = 1'b0;
            end else begin
               move_hit = 1'b1;
            end
         end else begin
            move_code.dac = code_ff.dac - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= '0;
         up_ff        <= 1'b0;
         remain_ff    <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  hit_ff    <= 1'b0;
                  up_ff     <= (req_tuser == CMD_UP);
                  remain_ff <= (req_count == '0) ? COUNT_W'(1) : req_count;
                  case (req_tuser)
                     CMD_LOAD: begin
                        code_ff.dac   <= (req_dac > DAC_TOP) ? DAC_TOP : req_dac;
                        code_ff.gm    <= req_gm;
                        code_ff.dummy <= req_dummy;
                        state_ff      <= ST_FINISH;
                     end
                     CMD_UP, CMD_DOWN: begin
                        state_ff <= ST_STEP;
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_STEP: begin
               code_ff   <= move_code;
               remain_ff <= remain_ff - COUNT_W'(1);
               if (move_hit) begin
                  hit_ff   <= 1'b1;
                  state_ff <= ST_FINISH;
               end else if (remain_ff == COUNT_W'(1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // a result taken this cycle is replaced here, otherwise the slot is empty
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {2'b00, hit_ff, code_ff.dummy, to_gray(code_ff.gm),
                                   code_ff.gm, code_ff.dac};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/pdcs_checker.sv =====
// Port-level checks for the phase DAC code stepper, bound to the top level.
module pdcs_checker import pdcs_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Gray field tracks the binary segment
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:9] == to_gray(rsp_tdata[8:6]))
      else $error("gm_gray does not match gm_binary");

   // DAC part never leaves its range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= DAC_TOP)
      else $error("dac_code out of range");

   // One command at a time: no acceptance in the cycle after one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while busy");

endmodule

bind phase_dac_code_stepper_core pdcs_checker u_pdcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the phase DAC code stepper: directed table, then random commands.
`timescale 1ns / 1ps

module tb_top;
   import pdcs_pkg::*;

   localparam logic [REQ_TUSER_W-1:0] CMD_NONE = 2'd3;  // unused command, holds the code
   localparam int RAND_ITEMS  = 450;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 300;
   localparam int STALL_LIMIT = 4000;

   // one result transaction, MSB first: hit, dummy, gray, gm, dac
   typedef struct packed {
      logic             hit;
      logic             dummy;
      logic [GM_W-1:0]  gray;
      logic [GM_W-1:0]  gm;
      logic [DAC_W-1:0] dac;
   } code_word_type;

   typedef struct packed {
      logic [REQ_TUSER_W-1:0] cmd;
      logic [COUNT_W-1:0]     cnt;
      logic [DAC_W-1:0]       ldac;
      logic [GM_W-1:0]        lgm;
      logic                   ldum;
      logic                   typed;
      logic [DAC_W-1:0]       e_dac;
      logic [GM_W-1:0]        e_gm;
      logic [GM_W-1:0]        e_gray;
      logic                   e_dum;
      logic                   e_hit;
   } stim_row_type;

   localparam int DIR_ROWS = 25;

   // cmd, count, load dac/gm/dummy, typed, expected dac/gm/gray/dummy/hit
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{CMD_DOWN, 8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd0,  3'd0, 3'd0, 1'b0, 1'b1},
      '{CMD_UP,   8'd0,   6'd0,  3'd0, 1'b0, 1'b1, 6'd1,  3'd0, 3'd0, 1'b0, 1'b0},
      '{CMD_LOAD, 8'd0,   6'd63, 3'd7, 1'b1, 1'b1, 6'd51, 3'd7, 3'd4, 1'b1, 1'b0},
      '{CMD_UP,   8'd5,   6'd0,  3'd0, 1'b0, 1'b1, 6'd51, 3'd7, 3'd4, 1'b1, 1'b1},
      '{CMD_DOWN, 8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd51, 3'd7, 3'd4, 1'b1, 1'b1},
      '{CMD_NONE, 8'd255, 6'd63, 3'd7, 1'b1, 1'b1, 6'd51, 3'd7, 3'd4, 1'b1, 1'b0},
      '{CMD_LOAD, 8'd0,   6'd49, 3'd7, 1'b0, 1'b1, 6'd49, 3'd7, 3'd4, 1'b0, 1'b0},
      '{CMD_UP,   8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd48, 3'd7, 3'd4, 1'b0, 1'b0},
      '{CMD_DOWN, 8'd2,   6'd0,  3'd0, 1'b0, 1'b1, 6'd51, 3'd6, 3'd5, 1'b0, 1'b0},
      '{CMD_UP,   8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd49, 3'd7, 3'd4, 1'b1, 1'b0},
      '{CMD_LOAD, 8'd0,   6'd49, 3'd6, 1'b1, 1'b1, 6'd49, 3'd6, 3'd5, 1'b1, 1'b0},
      '{CMD_UP,   8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd51, 3'd6, 3'd5, 1'b0, 1'b0},
      '{CMD_LOAD, 8'd0,   6'd50, 3'd3, 1'b0, 1'b1, 6'd50, 3'd3, 3'd2, 1'b0, 1'b0},
      '{CMD_UP,   8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd0,  3'd4, 3'd6, 1'b1, 1'b0},
      '{CMD_DOWN, 8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd51, 3'd3, 3'd2, 1'b0, 1'b0},
      '{CMD_DOWN, 8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd49, 3'd3, 3'd2, 1'b1, 1'b0},
      '{CMD_LOAD, 8'd0,   6'd49, 3'd2, 1'b0, 1'b1, 6'd49, 3'd2, 3'd3, 1'b0, 1'b0},
      '{CMD_UP,   8'd1,   6'd0,  3'd0, 1'b0, 1'b1, 6'd50, 3'd2, 3'd3, 1'b0, 1'b0},
      '{CMD_LOAD, 8'd0,   6'd0,  3'd7, 1'b0, 1'b1, 6'd0,  3'd7, 3'd4, 1'b0, 1'b0},
      '{CMD_UP,   8'd3,   6'd0,  3'd0, 1'b0, 1'b1, 6'd0,  3'd7, 3'd4, 1'b0, 1'b1},
      '{CMD_LOAD, 8'd0,   6'd1,  3'd1, 1'b1, 1'b1, 6'd1,  3'd1, 3'd1, 1'b1, 1'b0},
      '{CMD_DOWN, 8'd255, 6'd0,  3'd0, 1'b0, 1'b1, 6'd0,  3'd1, 3'd1, 1'b1, 1'b1},
      '{CMD_LOAD, 8'd0,   6'd0,  3'd0, 1'b0, 1'b1, 6'd0,  3'd0, 3'd0, 1'b0, 1'b0},
      '{CMD_UP,   8'd255, 6'd0,  3'd0, 1'b0, 1'b0, 6'd0,  3'd0, 3'd0, 1'b0, 1'b0},
      '{CMD_DOWN, 8'd255, 6'd0,  3'd0, 1'b0, 1'b0, 6'd0,  3'd0, 3'd0, 1'b0, 1'b0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [7:0] step_count, [13:8] load_dac, [16:14] load_gm, [17] load_dummy, [23:18] zero
   logic [REQ_TDATA_W-1:0] req_tdata;
   // [1:0] command
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [5:0] dac_code, [8:6] gm_binary, [11:9] gm_gray, [12] dummy_clock,
   // [13] end_stop, [15:14] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   code_type      code_now;
   code_word_type expected_codes [$];
   logic          no_idle;
   logic          hold_off_req;
   int            mismatches;
   int            codes_checked;
   int            boundary_stops;
   int            loads_sent;
   int            items_sent;
   int            stall_cycles;

   phase_dac_code_stepper_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // one position up the code space; returns 1 at the end
   function automatic logic step_up_once(inout code_type c);
      if (c.dac == DAC_TURN) begin
         if (c.gm == GM_PEN) begin
            c.dac   = DAC_TOP;
            c.dummy = 1'b0;
         end else if (c.gm == GM_TOP) begin
            c.dac = DAC_SEG_LOW;
         end else begin
            c.dac   = DAC_ALT;
            c.dummy = 1'b0;
         end
      end else if (c.dac == DAC_ALT || c.dac == DAC_TOP) begin
         if (c.gm == GM_PEN) begin
            c.dac   = DAC_TURN;
            c.gm    = GM_TOP;
            c.dummy = 1'b1;
         end else if (c.gm == GM_TOP) begin
            return 1'b1;
         end else begin
            c.dac   = DAC_ZERO;
            c.gm    = c.gm + 3'd1;
            c.dummy = 1'b1;
         end
      end else if (c.gm == GM_TOP) begin
         if (c.dac == DAC_ZERO) return 1'b1;
         c.dac = c.dac - 6'd1;  // top segment runs the DAC backwards
      end else begin
         c.dac = c.dac + 6'd1;
      end
      return 1'b0;
   endfunction

   // one position down the code space; returns 1 at the end
   function automatic logic step_down_once(inout code_type c);
      if (c.gm == GM_TOP) begin
         if (c.dac == DAC_TURN) begin
            c.dac   = DAC_TOP;
            c.gm    = GM_PEN;
            c.dummy = 1'b0;
         end else if (c.dac == DAC_ALT || c.dac == DAC_TOP) begin
            return 1'b1;
         end else begin
            c.dac = c.dac + 6'd1;
         end
      end else if (c.dac == DAC_ALT || c.dac == DAC_TOP) begin
         c.dac   = DAC_TURN;
         c.dummy = 1'b1;
      end else if (c.dac == DAC_ZERO) begin
         if (c.gm > GM_ONE) begin
            c.gm    = c.gm - 3'd1;
            c.dac   = DAC_TOP;
            c.dummy = 1'b0;
         end else begin
            return 1'b1;
         end
      end else begin
         c.dac = c.dac - 6'd1;
      end
      return 1'b0;
   endfunction

   // advances code_now by one command and gives the code word it produces
   function automatic code_word_type predict_code(input logic [REQ_TUSER_W-1:0] cmd,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic [DAC_W-1:0] ldac,
                                                  input logic [GM_W-1:0] lgm,
                                                  input logic ldum);
      code_word_type w;
      int            moves;
      int            i;
      logic          hit;
      hit   = 1'b0;
      moves = (cnt == 0) ? 1 : int'(cnt);
      case (cmd)
         CMD_LOAD: begin
            code_now.dac   = (ldac > DAC_TOP) ? DAC_TOP : ldac;
            code_now.gm    = lgm;
            code_now.dummy = ldum;
         end
         CMD_UP, CMD_DOWN: begin
            for (i = 0; i < moves && !hit; i++)
               hit = (cmd == CMD_UP) ? step_up_once(code_now) : step_down_once(code_now);
         end
         default: ;
      endcase
      w.dac   = code_now.dac;
      w.gm    = code_now.gm;
      w.gray  = code_now.gm ^ (code_now.gm >> 1);
      w.dummy = code_now.dummy;
      w.hit   = hit;
      return w;
   endfunction

   task automatic offer_item(input logic [REQ_TUSER_W-1:0] cmd,
                             input logic [COUNT_W-1:0] cnt,
                             input logic [DAC_W-1:0] ldac,
                             input logic [GM_W-1:0] lgm,
                             input logic ldum,
                             input logic typed,
                             input code_word_type typed_word);
      code_word_type w;
      while (!no_idle && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, ldum, lgm, ldac, cnt};
      do @(posedge clock); while (!req_tready);
      w = predict_code(cmd, cnt, ldac, lgm, ldum);
      expected_codes.push_back(typed ? typed_word : w);
      items_sent++;
      if (cmd == CMD_LOAD) loads_sent++;
   endtask

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int k;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      code_word_type got;
      code_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[13:0];
         if (got.hit) boundary_stops++;
         if (expected_codes.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected result dac=%0d gm=%0d gray=%0d dummy=%0d hit=%0d",
                        $realtime, got.dac, got.gm, got.gray, got.dummy, got.hit);
            mismatches++;
         end else begin
            want = expected_codes.pop_front();
            codes_checked++;
            if (got.dac !== want.dac || got.gm !== want.gm || got.gray !== want.gray ||
                got.dummy !== want.dummy || got.hit !== want.hit) begin
               if (mismatches < 10) begin
                  $display("%0t: code %0d exp dac=%0d gm=%0d gray=%0d dummy=%0d hit=%0d,",
                           $realtime, codes_checked, want.dac, want.gm, want.gray,
                           want.dummy, want.hit);
                  $display("   got dac=%0d gm=%0d gray=%0d dummy=%0d hit=%0d",
                           got.dac, got.gm, got.gray, got.dummy, got.hit);
               end
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  stall_cycles, expected_codes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int                     n;
      int                     pick;
      logic [REQ_TUSER_W-1:0] cmd;
      logic [COUNT_W-1:0]     cnt;
      logic [DAC_W-1:0]       ldac;
      logic [GM_W-1:0]        lgm;
      code_word_type          typed_word;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = CMD_LOAD;
      no_idle        = 1'b0;
      hold_off_req   = 1'b0;
      mismatches     = 0;
      codes_checked  = 0;
      boundary_stops = 0;
      loads_sent     = 0;
      items_sent     = 0;
      stall_cycles   = 0;
      code_now       = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIR_ROWS; n++) begin
         typed_word.dac   = dir_rows[n].e_dac;
         typed_word.gm    = dir_rows[n].e_gm;
         typed_word.gray  = dir_rows[n].e_gray;
         typed_word.dummy = dir_rows[n].e_dum;
         typed_word.hit   = dir_rows[n].e_hit;
         offer_item(dir_rows[n].cmd, dir_rows[n].cnt, dir_rows[n].ldac, dir_rows[n].lgm,
                    dir_rows[n].ldum, dir_rows[n].typed, typed_word);
      end

      typed_word = '0;
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n == 100) hold_off_req = 1'b1;
         if (n == 300) begin
            // let the pipeline drain completely before carrying on
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_codes.size() != 0);
         end
         no_idle = (n >= 180 && n < 260);

         pick = $urandom_range(0, 99);
         if (pick < 18)      cmd = CMD_LOAD;
         else if (pick < 21) cmd = CMD_NONE;
         else if (pick < 60) cmd = CMD_UP;
         else                cmd = CMD_DOWN;

         // mostly short moves so segment edges are crossed often
         pick = $urandom_range(0, 99);
         if (pick < 45)      cnt = COUNT_W'($urandom_range(0, 4));
         else if (pick < 80) cnt = COUNT_W'($urandom_range(0, 64));
         else                cnt = COUNT_W'($urandom_range(0, 255));

         case ($urandom_range(0, 5))
            0:       ldac = DAC_ZERO;
            1:       ldac = DAC_W'($urandom_range(47, 51));
            2:       ldac = DAC_W'($urandom_range(52, 63));
            default: ldac = DAC_W'($urandom_range(0, 63));
         endcase
         lgm = ($urandom_range(0, 3) == 0) ? GM_W'($urandom_range(6, 7))
                                           : GM_W'($urandom_range(0, 7));

         offer_item(cmd, cnt, ldac, lgm, 1'($urandom_range(0, 1)), 1'b0, typed_word);
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      while (expected_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      mismatches += expected_codes.size();

      $display("%0d commands (%0d loads) sent, %0d codes checked, %0d stopped at an end",
               items_sent, loads_sent, codes_checked, boundary_stops);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/pdcs_pkg.sv
design/phase_dac_code_stepper_core.sv
design/pdcs_checker.sv
test/tb_top.sv
